// ===== sv/nmea_pkg.sv =====
// Package for the NMEA sentence field extractor.
// Holds the parser state type, header and character constants and the digit pair decode.
// No dependencies.
package nmea_pkg;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_HEADER    = 3'd1,
        ST_HDR_OK    = 3'd2,
        ST_TIME_DONE = 3'd3,
        ST_FIX_NEXT  = 3'd4,
        ST_DATE_WAIT = 3'd5,
        ST_DATE      = 3'd6,
        ST_SATS      = 3'd7
    } t_parse_state;

    typedef enum logic [1:0] {
        FIX_NONE   = 2'd0,
        FIX_VOID   = 2'd1,
        FIX_ACTIVE = 2'd2
    } t_fix_flag;

    localparam logic [2:0] HDR_LEN     = 3'd7;
    localparam logic [2:0] DT_LEN      = 3'd6;
    localparam logic [2:0] SAT_LEN     = 3'd2;
    localparam logic [2:0] DATE_COMMAS = 3'd7;
    localparam logic [2:0] SAT_COMMAS  = 3'd2;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_V      = 8'h56;

    localparam logic [7:0] HDR_GSV [0:6] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56, 8'h2C};
    localparam logic [7:0] HDR_RMC [0:6] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43, 8'h2C};

    // For two ASCII decimal digits, returns (hi - '0') * 10 + (lo - '0').
    function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] v;
        v = {hi[4:0], 3'b000} + {hi[6:0], 1'b0} + lo - 8'd16;
        return v;
    endfunction

endpackage

// ===== sv/nmea_rmc_gsv_field_extractor_core.sv =====
// Top level of the NMEA sentence field extractor: byte parser and result register.
// Depends on nmea_pkg.
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_rx_byte
// result    out        o_out_valid / i_out_ready  o_sentence_kind, date, time, o_satellites_in_view,
//                                                 o_fix_seen, o_fix_active
//
// One byte is taken per cycle while o_in_ready is high; each byte is parsed in the cycle of its transfer.
// A result is written to the output register by the clock edge that takes the byte that completes it.
// The input is stalled only while a result is held and the output side is not ready.
// Reset returns the parser to idle and clears the satellite count and fix flag.
module nmea_rmc_gsv_field_extractor_core
    import nmea_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_sentence_kind,
    output logic [7:0] o_day,
    output logic [7:0] o_month,
    output logic [7:0] o_year_in_century,
    output logic [7:0] o_hour,
    output logic [7:0] o_minute,
    output logic [7:0] o_second,
    output logic [7:0] o_satellites_in_view,
    output logic       o_fix_seen,
    output logic       o_fix_active
);

    t_parse_state r_state, n_state;
    logic         r_type, n_type;
    logic [2:0]   r_count, n_count;
    logic         r_gsv_match, n_gsv_match;
    logic         r_rmc_match, n_rmc_match;
    t_fix_flag    r_fix, n_fix;
    logic [7:0]   r_sat_count, n_sat_count;

    logic [7:0]   r_time [0:5];
    logic [7:0]   r_date [0:4];
    logic [7:0]   r_sat_hi;

    logic         r_out_valid;
    logic         r_kind;
    logic [7:0]   r_day, r_month, r_year, r_hour, r_minute, r_second, r_sats;
    logic         r_fix_seen, r_fix_active;

    logic         w_accept;
    logic         w_emit;
    logic         w_kind;
    logic [7:0]   w_day, w_month, w_year, w_hour, w_minute, w_second;
    logic [2:0]   w_count_inc;
    logic [7:0]   w_c;

    assign w_c         = i_rx_byte;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_count_inc = r_count + 3'd1;

    always_comb begin
        n_state     = r_state;
        n_type      = r_type;
        n_count     = r_count;
        n_gsv_match = r_gsv_match;
        n_rmc_match = r_rmc_match;
        unique case (r_state)
            ST_IDLE: begin
                if (w_c == CHAR_DOLLAR) begin
                    n_count     = w_count_inc;
                    n_gsv_match = 1'b1;
                    n_rmc_match = 1'b1;
                    n_state     = ST_HEADER;
                end
            end
            ST_HEADER: begin
                n_gsv_match = r_gsv_match && (w_c == HDR_GSV[r_count]);
                n_rmc_match = r_rmc_match && (w_c == HDR_RMC[r_count]);
                n_count     = w_count_inc;
                if (w_count_inc >= HDR_LEN) begin
                    n_count = 3'd0;
                    if (n_gsv_match) begin
                        n_state = ST_HDR_OK;
                        n_type  = 1'b1;
                    end else if (n_rmc_match) begin
                        n_state = ST_HDR_OK;
                        n_type  = 1'b0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_HDR_OK: begin
                if (!r_type) begin
                    n_count = w_count_inc;
                    if (w_count_inc >= DT_LEN) begin
                        n_state = ST_TIME_DONE;
                        n_count = 3'd0;
                    end
                end else if (w_c == CHAR_COMMA) begin
                    n_count = w_count_inc;
                    if (w_count_inc >= SAT_COMMAS) begin
                        n_state = ST_SATS;
                        n_count = 3'd0;
                    end
                end
            end
            ST_TIME_DONE: begin
                if (w_c == CHAR_COMMA) begin
                    n_state = ST_FIX_NEXT;
                end
            end
            ST_FIX_NEXT: begin
                if (w_c == CHAR_A || w_c == CHAR_V) begin
                    n_state = ST_DATE_WAIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DATE_WAIT: begin
                if (w_c == CHAR_COMMA) begin
                    n_count = w_count_inc;
                    if (w_count_inc >= DATE_COMMAS) begin
                        n_state = ST_DATE;
                        n_count = 3'd0;
                    end
                end
            end
            ST_DATE: begin
                n_count = w_count_inc;
                if (w_count_inc >= DT_LEN) begin
                    n_state = ST_IDLE;
                    n_count = 3'd0;
                end
            end
            ST_SATS: begin
                n_count = w_count_inc;
                if (w_count_inc >= SAT_LEN) begin
                    n_state = ST_IDLE;
                    n_count = 3'd0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_fix       = r_fix;
        n_sat_count = r_sat_count;
        w_emit      = 1'b0;
        w_kind      = 1'b0;
        w_day       = 8'd0;
        w_month     = 8'd0;
        w_year      = 8'd0;
        w_hour      = 8'd0;
        w_minute    = 8'd0;
        w_second    = 8'd0;
        unique case (r_state)
            ST_FIX_NEXT: begin
                if (w_c == CHAR_A) begin
                    n_fix = FIX_ACTIVE;
                end else if (w_c == CHAR_V) begin
                    n_fix = FIX_VOID;
                end
            end
            ST_DATE: begin
                if (w_count_inc >= DT_LEN) begin
                    w_emit   = 1'b1;
                    w_day    = two_digits(r_date[0], r_date[1]);
                    w_month  = two_digits(r_date[2], r_date[3]);
                    w_year   = two_digits(r_date[4], w_c);
                    w_hour   = two_digits(r_time[0], r_time[1]);
                    w_minute = two_digits(r_time[2], r_time[3]);
                    w_second = two_digits(r_time[4], r_time[5]);
                end
            end
            ST_SATS: begin
                if (w_count_inc >= SAT_LEN) begin
                    w_emit      = 1'b1;
                    w_kind      = 1'b1;
                    n_sat_count = two_digits(r_sat_hi, w_c);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_type      <= 1'b0;
            r_count     <= 3'd0;
            r_gsv_match <= 1'b0;
            r_rmc_match <= 1'b0;
            r_fix       <= FIX_NONE;
            r_sat_count <= 8'd0;
        end else if (w_accept) begin
            r_state     <= n_state;
            r_type      <= n_type;
            r_count     <= n_count;
            r_gsv_match <= n_gsv_match;
            r_rmc_match <= n_rmc_match;
            r_fix       <= n_fix;
            r_sat_count <= n_sat_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_state == ST_HDR_OK && !r_type && r_count < DT_LEN) begin
                r_time[r_count] <= w_c;
            end
            if (r_state == ST_DATE && r_count < 3'd5) begin
                r_date[r_count] <= w_c;
            end
            if (r_state == ST_SATS && r_count == 3'd0) begin
                r_sat_hi <= w_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_kind       <= w_kind;
            r_day        <= w_day;
            r_month      <= w_month;
            r_year       <= w_year;
            r_hour       <= w_hour;
            r_minute     <= w_minute;
            r_second     <= w_second;
            r_sats       <= n_sat_count;
            r_fix_seen   <= (r_fix != FIX_NONE);
            r_fix_active <= (r_fix == FIX_ACTIVE);
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_sentence_kind      = r_kind;
    assign o_day                = r_day;
    assign o_month              = r_month;
    assign o_year_in_century    = r_year;
    assign o_hour               = r_hour;
    assign o_minute             = r_minute;
    assign o_second             = r_second;
    assign o_satellites_in_view = r_sats;
    assign o_fix_seen           = r_fix_seen;
    assign o_fix_active         = r_fix_active;

endmodule
